### rtl/aop_pkg.sv
package aop_pkg;

    // signed Q15.16 positions, unsigned Q14.16 extents
    localparam int COORD_FRAC_BITS = 16;

    localparam int POS_W  = 31;   // signed position
    localparam int SIZE_W = 30;   // unsigned extent
    localparam int WIDE_W = 33;   // signed sums and push components
    localparam int KIND_W = 2;
    localparam int AXIS_W = 3;

    localparam int FACE_COUNT = 6;
    localparam int PAIR_COUNT = FACE_COUNT / 2;

    // stream word layout
    localparam int S_FIELD_BITS = 6 * POS_W + 3 * SIZE_W;
    localparam int S_TDATA_W    = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 3 * WIDE_W;
    localparam int M_TDATA_W    = ((M_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W    = 1 + AXIS_W;

    localparam int CFG_INDEX_W = 2;

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic        [SIZE_W-1:0] size_t;
    typedef logic signed [WIDE_W-1:0] wide_t;
    typedef logic        [WIDE_W-1:0] mag_t;
    typedef logic        [AXIS_W-1:0] axis_t;
    typedef logic        [KIND_W-1:0] kind_t;

    localparam size_t A_SIZE_RESET = SIZE_W'(1 << COORD_FRAC_BITS);

    // pair kinds; anything else (mixed shapes) misses
    localparam kind_t KIND_BOX    = 2'd0;
    localparam kind_t KIND_SPHERE = 2'd1;

    // push faces +x,-x,+y,-y,+z,-z, then sphere vertical
    localparam axis_t FACE_POS_X  = 3'd0;
    localparam axis_t FACE_POS_Y  = 3'd2;
    localparam axis_t FACE_POS_Z  = 3'd4;
    localparam axis_t AXIS_SPHERE = 3'd6;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_A_SIZE_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_A_SIZE_Y = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_A_SIZE_Z = 2'd2;

    // advance strobes for the two compare stages
    typedef struct packed {
        logic adv_a;
        logic adv_b;
    } pipe_ctl_t;

    function automatic wide_t sx_pos(input pos_t v);
        return {{(WIDE_W - POS_W){v[POS_W-1]}}, v};
    endfunction

    function automatic wide_t zx_size(input size_t v);
        return {{(WIDE_W - SIZE_W){1'b0}}, v};
    endfunction

    function automatic mag_t abs_wide(input wide_t v);
        return v[WIDE_W-1] ? mag_t'(-v) : mag_t'(v);
    endfunction

endpackage

### rtl/aop_face_min.sv
module aop_face_min (
    input  logic               aclk,
    input  aop_pkg::pipe_ctl_t ctl,
    input  aop_pkg::mag_t      mag_i [aop_pkg::FACE_COUNT],
    output aop_pkg::axis_t     best_o
);
    import aop_pkg::*;

    mag_t  pmag_reg  [PAIR_COUNT];
    axis_t pidx_reg  [PAIR_COUNT];
    mag_t  pmag_next [PAIR_COUNT];
    axis_t pidx_next [PAIR_COUNT];
    axis_t best_reg;
    axis_t best_next;
    mag_t  m01;
    logic  sel1;

    // first level: lower face of each pair wins a tie
    always_comb begin
        for (int p = 0; p < PAIR_COUNT; p++) begin
            if (mag_i[2*p+1] < mag_i[2*p]) begin
                pmag_next[p] = mag_i[2*p+1];
                pidx_next[p] = AXIS_W'(2*p + 1);
            end else begin
                pmag_next[p] = mag_i[2*p];
                pidx_next[p] = AXIS_W'(2*p);
            end
        end
    end

    // second level: strict compares keep the earliest minimum
    always_comb begin
        sel1      = pmag_reg[1] < pmag_reg[0];
        m01       = sel1 ? pmag_reg[1] : pmag_reg[0];
        best_next = sel1 ? pidx_reg[1] : pidx_reg[0];
        if (pmag_reg[2] < m01) begin
            best_next = pidx_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv_a) begin
            pmag_reg <= pmag_next;
            pidx_reg <= pidx_next;
        end
        if (ctl.adv_b) begin
            best_reg <= best_next;
        end
    end

    assign best_o = best_reg;

endmodule

### rtl/aabb_overlap_push_out.sv
// An accepted input word passes through five register stages (sums, overlap and abs,
// pair minimum, final minimum, output register) to its result word on m_tdata/m_tuser.
// Throughput: one word per cycle unless m_tready stalls; each stage can take a new word each cycle.
// A stall on m_tready fills bubbles first; s_tready drops only when all stages hold words.
// Reset (aresetn low, synchronous): all stages empty, box A extents return to 1.0.
module aabb_overlap_push_out (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [aop_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aop_pkg::SIZE_W-1:0]      cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z, b_size_x, b_size_y, b_size_z
    input  logic [aop_pkg::S_TDATA_W-1:0]   s_tdata,
    // pair_kind
    input  logic [aop_pkg::KIND_W-1:0]      s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // push_x, push_y, push_z
    output logic [aop_pkg::M_TDATA_W-1:0]   m_tdata,
    // hit, push_axis
    output logic [aop_pkg::M_TUSER_W-1:0]   m_tuser
);
    import aop_pkg::*;

    // ------------------------------------------------------------------
    // Box A extents
    // ------------------------------------------------------------------
    size_t a_size_x_reg, a_size_y_reg, a_size_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_size_x_reg <= A_SIZE_RESET;
            a_size_y_reg <= A_SIZE_RESET;
            a_size_z_reg <= A_SIZE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_A_SIZE_X: a_size_x_reg <= cfg_data;
                CFG_A_SIZE_Y: a_size_y_reg <= cfg_data;
                CFG_A_SIZE_Z: a_size_z_reg <= cfg_data;
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage loads when it is empty or its
    // successor moves on, so bubbles close up under a stall.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, m_valid_reg;
    logic adv1, adv2, adv3, adv4, adv_o;
    pipe_ctl_t min_ctl;

    assign adv_o = !m_valid_reg  || m_tready;
    assign adv4  = !s4_valid_reg || adv_o;
    assign adv3  = !s3_valid_reg || adv4;
    assign adv2  = !s2_valid_reg || adv3;
    assign adv1  = !s1_valid_reg || adv2;

    assign s_tready      = adv1;
    assign min_ctl.adv_a = adv3;
    assign min_ctl.adv_b = adv4;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (adv1)  s1_valid_reg <= s_tvalid;
            if (adv2)  s2_valid_reg <= s1_valid_reg;
            if (adv3)  s3_valid_reg <= s2_valid_reg;
            if (adv4)  s4_valid_reg <= s3_valid_reg;
            if (adv_o) m_valid_reg  <= s4_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack the word, form the axis offsets and the six
    // signed face pushes. All sums are exact in 33 bits.
    // ------------------------------------------------------------------
    pos_t  in_ax, in_ay, in_az, in_bx, in_by, in_bz;
    size_t in_bsx, in_bsy, in_bsz;

    assign in_ax  = s_tdata[0*POS_W +: POS_W];
    assign in_ay  = s_tdata[1*POS_W +: POS_W];
    assign in_az  = s_tdata[2*POS_W +: POS_W];
    assign in_bx  = s_tdata[3*POS_W +: POS_W];
    assign in_by  = s_tdata[4*POS_W +: POS_W];
    assign in_bz  = s_tdata[5*POS_W +: POS_W];
    assign in_bsx = s_tdata[6*POS_W + 0*SIZE_W +: SIZE_W];
    assign in_bsy = s_tdata[6*POS_W + 1*SIZE_W +: SIZE_W];
    assign in_bsz = s_tdata[6*POS_W + 2*SIZE_W +: SIZE_W];

    wide_t s1_push_next [FACE_COUNT];
    wide_t s1_dx_next, s1_dy_next, s1_dz_next;

    always_comb begin
        // the y offset runs B minus A, the others A minus B
        s1_dx_next = sx_pos(in_ax) - sx_pos(in_bx);
        s1_dy_next = sx_pos(in_by) - sx_pos(in_ay);
        s1_dz_next = sx_pos(in_az) - sx_pos(in_bz);

        s1_push_next[0] = sx_pos(in_bx) - sx_pos(in_ax) - zx_size(a_size_x_reg);
        s1_push_next[1] = sx_pos(in_bx) + zx_size(in_bsx) - sx_pos(in_ax);
        s1_push_next[2] = sx_pos(in_by) - sx_pos(in_ay) + zx_size(a_size_y_reg);
        s1_push_next[3] = (sx_pos(in_ay) + zx_size(a_size_y_reg))
                        - (sx_pos(in_by) + zx_size(in_bsy));
        s1_push_next[4] = sx_pos(in_bz) - sx_pos(in_az) - zx_size(a_size_z_reg);
        s1_push_next[5] = sx_pos(in_bz) + zx_size(in_bsz) - sx_pos(in_az);
    end

    kind_t s1_kind_reg;
    wide_t s1_dx_reg, s1_dy_reg, s1_dz_reg;
    size_t s1_bsx_reg, s1_bsy_reg, s1_bsz_reg;
    wide_t s1_push_reg [FACE_COUNT];

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_kind_reg <= s_tuser;
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_dz_reg   <= s1_dz_next;
            s1_bsx_reg  <= in_bsx;
            s1_bsy_reg  <= in_bsy;
            s1_bsz_reg  <= in_bsz;
            s1_push_reg <= s1_push_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: inclusive overlap on all three axes, face magnitudes. Extents of A
    // are to be kept stable by the user while words are in flight; not enforced here.
    // ------------------------------------------------------------------
    logic  s2_overlap_next;
    mag_t  s2_mag_next [FACE_COUNT];

    always_comb begin
        s2_overlap_next = (s1_kind_reg == KIND_BOX)
            && (s1_dx_reg >= -zx_size(a_size_x_reg)) && (s1_dx_reg <= zx_size(s1_bsx_reg))
            && (s1_dy_reg >= -zx_size(a_size_y_reg)) && (s1_dy_reg <= zx_size(s1_bsy_reg))
            && (s1_dz_reg >= -zx_size(a_size_z_reg)) && (s1_dz_reg <= zx_size(s1_bsz_reg));
        for (int f = 0; f < FACE_COUNT; f++) begin
            s2_mag_next[f] = abs_wide(s1_push_reg[f]);
        end
    end

    logic  s2_sphere_reg, s2_hit_reg;
    wide_t s2_dy_reg;
    wide_t s2_push_reg [FACE_COUNT];
    mag_t  s2_mag_reg  [FACE_COUNT];

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_sphere_reg <= (s1_kind_reg == KIND_SPHERE);
            s2_hit_reg    <= s2_overlap_next;
            s2_dy_reg     <= s1_dy_reg;
            s2_push_reg   <= s1_push_reg;
            s2_mag_reg    <= s2_mag_next;
        end
    end

    // ------------------------------------------------------------------
    // Stages 3 and 4: least-penetration face, two compare levels.
    // The flags and pushes ride alongside.
    // ------------------------------------------------------------------
    axis_t best_face;

    aop_face_min u_face_min (
        .aclk   (aclk),
        .ctl    (min_ctl),
        .mag_i  (s2_mag_reg),
        .best_o (best_face)
    );

    logic  s3_sphere_reg, s3_hit_reg, s4_sphere_reg, s4_hit_reg;
    wide_t s3_dy_reg, s4_dy_reg;
    wide_t s3_push_reg [FACE_COUNT];
    wide_t s4_push_reg [FACE_COUNT];

    always_ff @(posedge aclk) begin
        if (adv3) begin
            s3_sphere_reg <= s2_sphere_reg;
            s3_hit_reg    <= s2_hit_reg;
            s3_dy_reg     <= s2_dy_reg;
            s3_push_reg   <= s2_push_reg;
        end
        if (adv4) begin
            s4_sphere_reg <= s3_sphere_reg;
            s4_hit_reg    <= s3_hit_reg;
            s4_dy_reg     <= s3_dy_reg;
            s4_push_reg   <= s3_push_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: place the chosen push on its axis, zero the rest.
    // A miss sends all zeros.
    // ------------------------------------------------------------------
    logic  out_hit;
    axis_t out_axis;
    wide_t out_px, out_py, out_pz;
    wide_t sel_push;

    assign sel_push = s4_push_reg[best_face];

    always_comb begin
        out_hit  = 1'b0;
        out_axis = FACE_POS_X;
        out_px   = '0;
        out_py   = '0;
        out_pz   = '0;
        if (s4_sphere_reg) begin
            out_hit  = 1'b1;
            out_axis = AXIS_SPHERE;
            out_py   = s4_dy_reg;
        end else if (s4_hit_reg) begin
            out_hit  = 1'b1;
            out_axis = best_face;
            if (best_face < FACE_POS_Y) begin
                out_px = sel_push;
            end else if (best_face < FACE_POS_Z) begin
                out_py = sel_push;
            end else begin
                out_pz = sel_push;
            end
        end
    end

    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (adv_o) begin
            m_tdata_reg <= {{(M_TDATA_W - M_FIELD_BITS){1'b0}}, out_pz, out_py, out_px};
            m_tuser_reg <= {out_axis, out_hit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### rtl/aop_checker.sv
module aop_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [aop_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [aop_pkg::M_TUSER_W-1:0]   m_tuser
);
    import aop_pkg::*;

    logic  c_hit;
    axis_t c_axis;
    wide_t c_px, c_py, c_pz;

    assign c_hit  = m_tuser[0];
    assign c_axis = m_tuser[AXIS_W:1];
    assign c_px   = m_tdata[0*WIDE_W +: WIDE_W];
    assign c_py   = m_tdata[1*WIDE_W +: WIDE_W];
    assign c_pz   = m_tdata[2*WIDE_W +: WIDE_W];

    // hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a miss carries face zero and no push
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !c_hit |-> c_axis == FACE_POS_X && c_px == '0 && c_py == '0 && c_pz == '0)
        else $error("miss word carries a push");

    // a push stays on one axis
    a_one_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && c_hit |->
            (c_axis < FACE_POS_Y && c_py == '0 && c_pz == '0) ||
            (c_axis >= FACE_POS_Y && c_axis < FACE_POS_Z && c_px == '0 && c_pz == '0) ||
            (c_axis >= FACE_POS_Z && c_axis < AXIS_SPHERE && c_px == '0 && c_py == '0) ||
            (c_axis == AXIS_SPHERE && c_px == '0 && c_pz == '0))
        else $error("push on more than one axis");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule

bind aabb_overlap_push_out aop_checker u_aop_checker (.*);

### tb/tb_aabb_overlap_push_out.sv
`timescale 1ns / 100ps

// Box A (extents in the config registers) is tested against one box B per
// input word. Each accepted word is run through a behavioral model of the
// overlap test and the minimum-penetration face choice. The expected push is
// queued, and each result word is checked in order against it. Stimulus is a
// short run of edge cases: bounds hit exactly and missed by one, tied faces,
// sphere and mixed pairs, extreme corners. Random pairs follow under several
// extent settings, most of them built to overlap. Both stream sides idle at
// random, and one stretch holds the result side off long enough to back up
// the pipe.
module tb_aabb_overlap_push_out;

    import aop_pkg::*;

    localparam int     PIPE_LATENCY = 5;
    localparam int     LONG_HOLD    = 300;
    localparam int     CYCLE_LIMIT  = 1_000_000;
    localparam int     SHOW_LIMIT   = 10;
    localparam longint POS_MAX      = 64'sd1073741823;
    localparam longint POS_MIN      = -64'sd1073741824;
    localparam longint ONE          = 64'sd1 << COORD_FRAC_BITS;
    localparam size_t  SIZE_TOP     = '1;

    // pair kinds the package leaves unnamed; both behave as mixed shapes
    localparam kind_t KIND_MIXED = kind_t'(2);
    localparam kind_t KIND_SPARE = kind_t'(3);

    // register index past the end of the list; the block drops such writes
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = CFG_INDEX_W'(3);

    typedef struct {
        kind_t kind;
        pos_t  ax, ay, az;
        pos_t  bx, by, bz;
        size_t bsx, bsy, bsz;
    } pair_rec_t;

    typedef struct {
        logic  hit;
        axis_t axis;
        wide_t px, py, pz;
    } push_rec_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]      cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [KIND_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // model copy of box A's extents, tracks every register write
    size_t ext_x = A_SIZE_RESET;
    size_t ext_y = A_SIZE_RESET;
    size_t ext_z = A_SIZE_RESET;

    push_rec_t   pending_pushes[$];
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // steady: no idling on either side; long_hold_req: result side holds off
    bit steady        = 1'b0;
    bit long_hold_req = 1'b0;

    aabb_overlap_push_out uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // a_pos_x/y/z, b_pos_x/y/z, b_size_x/y/z
        .s_tuser   (s_tuser),   // pair_kind
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // push_x, push_y, push_z
        .m_tuser   (m_tuser)    // hit, push_axis
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Push prediction
    // ------------------------------------------------------------------

    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic push_rec_t predict_push(input pair_rec_t p);
        longint    ax, ay, az, bx, by, bz;
        longint    bsx, bsy, bsz, asx, asy, asz;
        longint    face[FACE_COUNT];
        int        best;
        push_rec_t r;
        ax  = p.ax;  ay  = p.ay;  az  = p.az;
        bx  = p.bx;  by  = p.by;  bz  = p.bz;
        bsx = p.bsx; bsy = p.bsy; bsz = p.bsz;
        asx = ext_x; asy = ext_y; asz = ext_z;
        r.hit  = 1'b0;
        r.axis = FACE_POS_X;
        r.px   = '0;
        r.py   = '0;
        r.pz   = '0;
        // spheres always touch and are pushed straight up or down
        if (p.kind == KIND_SPHERE) begin
            r.hit  = 1'b1;
            r.axis = AXIS_SPHERE;
            r.py   = wide_t'(by - ay);
            return r;
        end
        if (p.kind != KIND_BOX)
            return r;
        // inclusive bounds; y is measured as B minus A
        if (ax - bx < -asx || ax - bx > bsx ||
            by - ay < -asy || by - ay > bsy ||
            az - bz < -asz || az - bz > bsz)
            return r;
        face[0] = bx - ax - asx;
        face[1] = bx + bsx - ax;
        face[2] = by - ay + asy;
        face[3] = (ay + asy) - (by + bsy);
        face[4] = bz - az - asz;
        face[5] = bz + bsz - az;
        // strict compare keeps the lowest face on a tie
        best = 0;
        for (int i = 1; i < FACE_COUNT; i++) begin
            if (magnitude(face[i]) < magnitude(face[best]))
                best = i;
        end
        r.hit  = 1'b1;
        r.axis = axis_t'(best);
        if (r.axis < FACE_POS_Y)
            r.px = wide_t'(face[best]);
        else if (r.axis < FACE_POS_Z)
            r.py = wide_t'(face[best]);
        else
            r.pz = wide_t'(face[best]);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pair construction
    // ------------------------------------------------------------------

    function automatic logic [S_TDATA_W-1:0] pack_pair(input pair_rec_t p);
        return S_TDATA_W'({p.bsz, p.bsy, p.bsx, p.bz, p.by, p.bx, p.az, p.ay, p.ax});
    endfunction

    function automatic pair_rec_t make_pair(input kind_t kind,
                                            input longint ax, ay, az, bx, by, bz,
                                            input size_t bsx, bsy, bsz);
        pair_rec_t p;
        p.kind = kind;
        p.ax   = pos_t'(ax);
        p.ay   = pos_t'(ay);
        p.az   = pos_t'(az);
        p.bx   = pos_t'(bx);
        p.by   = pos_t'(by);
        p.bz   = pos_t'(bz);
        p.bsx  = bsx;
        p.bsy  = bsy;
        p.bsz  = bsz;
        return p;
    endfunction

    function automatic longint span_pick(input longint lo, hi);
        return lo + longint'($urandom_range(32'(hi - lo), 0));
    endfunction

    // extent with a random bit length, so small and huge boxes both show up
    function automatic size_t scaled_extent();
        int k;
        k = $urandom_range(SIZE_W, 0);
        return size_t'($urandom >> (32 - k));
    endfunction

    // half full-range coordinates, half magnitudes of random bit length
    function automatic longint scaled_coord();
        int     k;
        longint mag;
        if ($urandom_range(1, 0))
            return longint'(pos_t'($urandom));
        k   = $urandom_range(POS_W - 1, 0);
        mag = longint'($urandom >> (32 - k));
        return $urandom_range(1, 0) ? -mag : mag;
    endfunction

    // land on a bound now and then, otherwise anywhere inside
    function automatic longint offset_between(input longint lo, hi);
        int pick;
        pick = $urandom_range(99, 0);
        if (pick < 20)
            return lo;
        if (pick < 40)
            return hi;
        return span_pick(lo, hi);
    endfunction

    // choose first and second with first - second == diff, both in range
    function automatic void place_apart(input longint diff,
                                        output longint first, output longint second);
        longint lo, hi, pick;
        lo   = (diff > 0) ? POS_MIN + diff : POS_MIN;
        hi   = (diff < 0) ? POS_MAX + diff : POS_MAX;
        pick = scaled_coord();
        if (pick < lo)
            pick = lo;
        else if (pick > hi)
            pick = hi;
        first  = pick;
        second = pick - diff;
    endfunction

    // dx = ax - bx, ey = by - ay, dz = az - bz
    function automatic pair_rec_t offsets_pair(input kind_t kind,
                                               input longint dx, ey, dz,
                                               input size_t bsx, bsy, bsz);
        longint ax, ay, az, bx, by, bz;
        place_apart(dx, ax, bx);
        place_apart(ey, by, ay);
        place_apart(dz, az, bz);
        return make_pair(kind, ax, ay, az, bx, by, bz, bsx, bsy, bsz);
    endfunction

    // box pair that overlaps, or misses by one on miss_axis (0..2)
    function automatic pair_rec_t box_pair(input int miss_axis);
        size_t  bsx, bsy, bsz;
        longint dx, ey, dz;
        bsx = scaled_extent();
        bsy = scaled_extent();
        bsz = scaled_extent();
        dx  = offset_between(-longint'(ext_x), longint'(bsx));
        ey  = offset_between(-longint'(ext_y), longint'(bsy));
        dz  = offset_between(-longint'(ext_z), longint'(bsz));
        case (miss_axis)
            0: dx = $urandom_range(1, 0) ? -longint'(ext_x) - 1 : longint'(bsx) + 1;
            1: ey = $urandom_range(1, 0) ? -longint'(ext_y) - 1 : longint'(bsy) + 1;
            2: dz = $urandom_range(1, 0) ? -longint'(ext_z) - 1 : longint'(bsz) + 1;
            default: ;
        endcase
        return offsets_pair(KIND_BOX, dx, ey, dz, bsx, bsy, bsz);
    endfunction

    function automatic pair_rec_t loose_pair(input kind_t kind);
        return make_pair(kind,
                         longint'(pos_t'($urandom)), longint'(pos_t'($urandom)),
                         longint'(pos_t'($urandom)), longint'(pos_t'($urandom)),
                         longint'(pos_t'($urandom)), longint'(pos_t'($urandom)),
                         size_t'($urandom), size_t'($urandom), size_t'($urandom));
    endfunction

    // mostly overlapping boxes, then near misses, spheres, mixed and raw noise
    function automatic pair_rec_t random_pair();
        int        pick;
        pair_rec_t p;
        pick = $urandom_range(99, 0);
        if (pick < 62) begin
            p = box_pair(-1);
        end else if (pick < 74) begin
            p = box_pair($urandom_range(2, 0));
        end else if (pick < 84) begin
            p = loose_pair(KIND_SPHERE);
        end else if (pick < 92) begin
            p = $urandom_range(1, 0) ? box_pair(-1) : loose_pair(KIND_BOX);
            p.kind = $urandom_range(1, 0) ? KIND_MIXED : KIND_SPARE;
        end else begin
            p = loose_pair(KIND_BOX);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Stream drivers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, a few long
    function automatic int gap_len();
        int pick;
        if (steady)
            return 0;
        pick = $urandom_range(99, 0);
        if (pick < 55)
            return 0;
        if (pick < 85)
            return $urandom_range(3, 1);
        if (pick < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // Offer one word and hold it until taken. Keep tvalid high across
    // back-to-back words; drop it only for a gap.
    task automatic send_pair(input pair_rec_t p);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_pair(p);
        s_tuser  <= p.kind;
        do @(posedge aclk); while (!s_tready);
        pending_pushes.push_back(predict_push(p));
    endtask

    // Drop tvalid, wait out every expected result, then let the pipe settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_pushes.size() != 0);
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic write_extents(input size_t x, y, z);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_A_SIZE_X;
        cfg_data  <= x;
        @(posedge aclk);
        cfg_index <= CFG_A_SIZE_Y;
        cfg_data  <= y;
        @(posedge aclk);
        cfg_index <= CFG_A_SIZE_Z;
        cfg_data  <= z;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        ext_x = x;
        ext_y = y;
        ext_z = z;
    endtask

    // write to an index past the list; the model state stays as is
    task automatic write_spare(input size_t value);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SPARE;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // random words with an idle-free stretch every fifth block of forty
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            steady = ((i / 40) % 5 == 4);
            send_pair(random_pair());
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern and checker
    // ------------------------------------------------------------------

    initial begin
        int stall_left;
        int gap;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                // hold off long enough for every stage to fill and s_tready to drop
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                gap = ($urandom_range(2, 0) == 0) ? gap_len() : 0;
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready   <= 1'b0;
                    stall_left = gap - 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        push_rec_t want;
        push_rec_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.hit  = m_tuser[0];
            got.axis = m_tuser[AXIS_W:1];
            got.px   = m_tdata[WIDE_W-1:0];
            got.py   = m_tdata[2*WIDE_W-1:WIDE_W];
            got.pz   = m_tdata[3*WIDE_W-1:2*WIDE_W];
            if (pending_pushes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("unexpected result word: hit=%0d axis=%0d push=(%0d,%0d,%0d)",
                             got.hit, got.axis, got.px, got.py, got.pz);
            end else begin
                want = pending_pushes.pop_front();
                if (got.hit !== want.hit || got.axis !== want.axis ||
                    got.px !== want.px || got.py !== want.py || got.pz !== want.pz) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("push mismatch: expected hit=%0d axis=%0d push=(%0d,%0d,%0d) %s",
                                 want.hit, want.axis, want.px, want.py, want.pz,
                                 $sformatf("got hit=%0d axis=%0d push=(%0d,%0d,%0d)",
                                           got.hit, got.axis, got.px, got.py, got.pz));
                end
            end
        end
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Edge cases under the reset extents of 1.0 on every axis.
    task automatic test_directed();
        // centered boxes: the x faces tie, but the -y face has no push and wins
        send_pair(offsets_pair(KIND_BOX, 0, 0, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        // each bound met exactly, then missed by one
        send_pair(offsets_pair(KIND_BOX, -ONE, 0, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, ONE, 0, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, -ONE - 1, 0, 0,
                               size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, ONE + 1, 0, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, -ONE, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, ONE, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, -ONE - 1, 0,
                               size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, ONE + 1, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, 0, -ONE, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, 0, ONE, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, 0, -ONE - 1,
                               size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, 0, ONE + 1, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        // uneven offsets and a flat box B so different faces come out on top
        send_pair(offsets_pair(KIND_BOX, ONE / 2, -ONE / 4, ONE / 8,
                               size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_BOX, -ONE / 2, ONE / 3, -ONE + 7,
                               size_t'(4 * ONE), size_t'(3 * ONE), size_t'(2 * ONE)));
        send_pair(offsets_pair(KIND_BOX, 0, 0, 0, '0, '0, '0));
        // spheres at opposite extremes give the largest vertical push both ways
        send_pair(make_pair(KIND_SPHERE, 0, POS_MIN, 0, 0, POS_MAX, 0,
                            SIZE_TOP, SIZE_TOP, SIZE_TOP));
        send_pair(make_pair(KIND_SPHERE, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN,
                            '0, '0, '0));
        // mixed and unused kinds miss even when the boxes overlap
        send_pair(offsets_pair(KIND_MIXED, 0, 0, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        send_pair(offsets_pair(KIND_SPARE, 0, 0, 0, size_t'(ONE), size_t'(ONE), size_t'(ONE)));
        // corners of the coordinate range
        send_pair(make_pair(KIND_BOX, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                            SIZE_TOP, SIZE_TOP, SIZE_TOP));
        send_pair(make_pair(KIND_BOX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                            '0, '0, '0));
        send_pair(make_pair(KIND_BOX, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN,
                            SIZE_TOP, SIZE_TOP, SIZE_TOP));
        wait_drained();
    endtask

    task automatic test_reset_extents();
        run_random(320);
        wait_drained();
    endtask

    // Hold the result side off while the sender keeps offering back to back.
    task automatic test_backpressure_fill();
        steady        = 1'b1;
        long_hold_req = 1'b1;
        for (int i = 0; i < 80; i++)
            send_pair(random_pair());
        steady = 1'b0;
        wait_drained();
    endtask

    task automatic test_zero_extents();
        write_extents('0, '0, '0);
        run_random(280);
        wait_drained();
    endtask

    task automatic test_max_extents();
        write_extents(SIZE_TOP, SIZE_TOP, SIZE_TOP);
        run_random(280);
        wait_drained();
    endtask

    // Uneven extents per axis; one phase also writes the unused index.
    task automatic test_mixed_extents();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_extents(SIZE_TOP, '0, scaled_extent());
                1: begin
                    write_spare(size_t'($urandom));
                    write_extents(scaled_extent(), scaled_extent(), scaled_extent());
                end
                default: write_extents('0, scaled_extent(), SIZE_TOP);
            endcase
            run_random(110);
            wait_drained();
        end
    endtask

    // Bursts separated by a full drain of the pipe.
    task automatic test_drain_pause();
        for (int burst = 0; burst < 2; burst++) begin
            run_random(60);
            wait_drained();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_reset_extents();
        test_backpressure_fill();
        test_zero_extents();
        test_max_extents();
        test_mixed_extents();
        test_drain_pause();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
